/* sv/bdq_pkg.sv */
package bdq_pkg;

	// Word width of one stored element and default ring depth.
	localparam int WORD_W    = 32;
	localparam int DEPTH_DEF = 64;

	// Request codes carried on req_type.
	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_DUMP   = 2'd3
	} req_t;

	// Status codes returned with every result word.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

endpackage

/* sv/bdq_ram.sv */
module bdq_ram #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(bdq_pkg::DEPTH_DEF)
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic signed [bdq_pkg::WORD_W-1:0]  wdata,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic signed [bdq_pkg::WORD_W-1:0]  rdata
);

	import bdq_pkg::*;

	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/bounded_deque_engine.sv */
// Every request gives its first result word in the cycle after acceptance.
// Append, insert and remove can be accepted back to back; a dump of N held words
// keeps busy high until its final read has been issued (not at all for N = 1) and
// streams N words without gaps, set by the single read port of the element memory.
// Reset (arst_n low) empties the sequence and clears all control state at once.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module bounded_deque_engine #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bdq_pkg::req_t                   req_type,
	input  logic signed [bdq_pkg::WORD_W-1:0] value_in,
	output logic                            strobe,
	output logic signed [bdq_pkg::WORD_W-1:0] value_out,
	output bdq_pkg::status_t                status,
	output logic                            last
);

	import bdq_pkg::*;

	// Slot index width and element count width (the count must hold DEPTH itself).
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// Step a slot index forward or backward around the ring.
	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		logic [AW-1:0] r;
		if (s == AW'(DEPTH - 1)) r = '0;
		else r = s + AW'(1);
		return r;
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		logic [AW-1:0] r;
		if (s == '0) r = AW'(DEPTH - 1);
		else r = s - AW'(1);
		return r;
	endfunction

	// Ring bookkeeping: the slot of the front word and the number of held words.
	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;

	// Dump sequencer: next slot to read and the number of reads still to issue.
	state_t        state_q, state_d;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] rem_q;

	// Result word registers; the memory read data joins them at the output.
	logic          strobe_q;
	status_t       status_q;
	logic          last_q;
	logic          sel_mem_s1;

	logic          accept;
	logic          full;
	logic          empty;
	logic [SW-1:0] back_sum;
	logic [AW-1:0] back_slot;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic signed [WORD_W-1:0] mem_rdata;

	// A request is taken only while no dump is streaming.
	assign accept = start && !busy;
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	// The back slot is front + count wrapped once; it is only used when not full,
	// so the sum stays below twice the depth and one subtraction suffices.
	assign back_sum  = SW'(front_q) + SW'(count_q);
	assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
	assign front_dec = slot_dec(front_q);
	assign front_inc = slot_inc(front_q);

	// Next state: a dump of two or more words enters the streaming state, which
	// leaves once the final read has been issued.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_DUMP) && (count_q > CW'(1))) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (rem_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State machine outputs: busy and the memory read port. The first word of a
	// dump is read in the cycle the request is accepted, the rest while streaming.
	always_comb begin
		busy      = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = front_q;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = accept && (req_type == REQ_DUMP) && !empty;
			end
			ST_DUMP: begin
				busy      = 1'b1;
				mem_re    = 1'b1;
				mem_raddr = ptr_q;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// Append writes behind the back word, insert writes in front of the front word.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = back_slot;
		if (accept && !full) begin
			if (req_type == REQ_APPEND) begin
				mem_we = 1'b1;
			end else if (req_type == REQ_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = front_dec;
			end
		end
	end

	bdq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (value_in),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Ring pointers and the dump sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (req_type)
					REQ_APPEND: begin
						if (!full) count_q <= count_q + CW'(1);
					end
					REQ_INSERT: begin
						if (!full) begin
							front_q <= front_dec;
							count_q <= count_q + CW'(1);
						end
					end
					REQ_REMOVE: begin
						if (!empty) begin
							front_q <= front_inc;
							count_q <= count_q - CW'(1);
						end
					end
					REQ_DUMP: begin
						ptr_q <= front_inc;
						rem_q <= count_q - CW'(1);
					end
					default: begin
						ptr_q <= ptr_q;
					end
				endcase
			end else if (state_q == ST_DUMP) begin
				ptr_q <= slot_inc(ptr_q);
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	// Result word strobe; only this control bit needs a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= accept || (state_q == ST_DUMP);
		end
	end

	// Result word payload: status, last marker and whether the value comes from memory.
	always_ff @(posedge clk) begin
		if (state_q == ST_DUMP) begin
			status_q   <= STATUS_OK;
			last_q     <= (rem_q == CW'(1));
			sel_mem_s1 <= 1'b1;
		end else begin
			last_q     <= 1'b1;
			sel_mem_s1 <= 1'b0;
			status_q   <= STATUS_OK;
			unique case (req_type)
				REQ_APPEND, REQ_INSERT: begin
					if (full) status_q <= STATUS_FULL;
				end
				REQ_REMOVE: begin
					if (empty) status_q <= STATUS_EMPTY;
				end
				REQ_DUMP: begin
					if (empty) begin
						status_q <= STATUS_EMPTY;
					end else begin
						sel_mem_s1 <= 1'b1;
						last_q     <= (count_q == CW'(1));
					end
				end
				default: begin
					status_q <= STATUS_OK;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign last      = last_q;
	assign value_out = sel_mem_s1 ? mem_rdata : '0;

	// The count never exceeds the ring depth and the front slot stays in range.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count beyond depth");

	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_q < AW'(DEPTH - 1) || front_q == AW'(DEPTH - 1))
		else $error("front slot out of range");

	// Every accepted request produces a result word in the next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> strobe)
		else $error("accepted request gave no result word");

	// A dump streams without gaps until its last word.
	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside dump stream");

	// Streaming only happens with words held and reads still to issue.
	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (count_q != '0) && (rem_q != '0))
		else $error("dump streaming with nothing held");

endmodule

/* sim/bounded_deque_engine_checker.sv */
module bounded_deque_engine_checker #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  bdq_pkg::req_t                     req_type,
	input  logic signed [bdq_pkg::WORD_W-1:0] value_in,
	input  logic                              strobe,
	input  logic signed [bdq_pkg::WORD_W-1:0] value_out,
	input  bdq_pkg::status_t                  status,
	input  logic                              last,
	output int                                mismatches,
	output int                                outstanding,
	output int                                words_checked,
	output int                                full_hits,
	output int                                empty_hits
);

	import bdq_pkg::*;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		status_t                  status;
		logic                     last;
	} result_word_t;

	// Mirror of the held sequence, front at index 0, and the result words still owed.
	logic signed [WORD_W-1:0] held_words[$];
	result_word_t             owed_words[$];

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		words_checked = 0;
		full_hits     = 0;
		empty_hits    = 0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic owe_word(input logic signed [WORD_W-1:0] v, input status_t s,
			input logic l);
		result_word_t w;
		w.value  = v;
		w.status = s;
		w.last   = l;
		owed_words = {owed_words, w};
	endtask

	task automatic predict_request(input req_t r, input logic signed [WORD_W-1:0] v);
		int n;
		n = held_words.size();
		case (r)
			REQ_APPEND, REQ_INSERT: begin
				if (n >= DEPTH) begin
					owe_word('0, STATUS_FULL, 1'b1);
					full_hits++;
				end else begin
					if (r == REQ_APPEND)
						held_words = {held_words, v};
					else
						held_words = {v, held_words};
					owe_word('0, STATUS_OK, 1'b1);
				end
			end
			REQ_REMOVE: begin
				if (n == 0) begin
					owe_word('0, STATUS_EMPTY, 1'b1);
					empty_hits++;
				end else begin
					void'(held_words.pop_front());
					owe_word('0, STATUS_OK, 1'b1);
				end
			end
			REQ_DUMP: begin
				if (n == 0) begin
					owe_word('0, STATUS_EMPTY, 1'b1);
					empty_hits++;
				end else begin
					for (int i = 0; i < n; i++)
						owe_word(held_words[i], STATUS_OK, (i == n - 1));
				end
			end
			default: report_mismatch($sformatf("unknown request code %b", r));
		endcase
	endtask

	// Results are compared before the request of the same edge is predicted: a
	// request never produces a word at the edge that accepts it.
	always @(posedge clk) begin : watch
		result_word_t want;
		if (arst_n) begin
			if (strobe) begin
				words_checked++;
				if (owed_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word value %0d status %0d last %0b",
						value_out, status, last));
				end else begin
					want = owed_words.pop_front();
					if (value_out !== want.value)
						report_mismatch($sformatf("value_out %0d, expected %0d",
							value_out, want.value));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
					if (last !== want.last)
						report_mismatch($sformatf("last %b, expected %b", last, want.last));
				end
			end
			if (start && !busy)
				predict_request(req_type, value_in);
			outstanding <= owed_words.size();
		end
	end

endmodule

/* sim/bounded_deque_engine_tb.sv */
module bounded_deque_engine_tb;

	import bdq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 200;
	// The limit sits far above the slowest correct run, in which every request is a full
	// dump of 64 words plus the longest sender gap. This leaves ample margin.
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic signed [WORD_W-1:0] MAX_WORD = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] MIN_WORD = {1'b1, {(WORD_W-1){1'b0}}};

	// Shape of the random stimulus: push-heavy, remove-heavy or balanced.
	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	req_t                     req_type;
	logic signed [WORD_W-1:0] value_in;
	logic                     strobe;
	logic signed [WORD_W-1:0] value_out;
	status_t                  status;
	logic                     last;

	int mismatches;
	int outstanding;
	int words_checked;
	int full_hits;
	int empty_hits;

	int cycle_count = 0;
	int burst_left  = 0;
	int sent_by_kind[4];

	always #5 clk = ~clk;

	bounded_deque_engine #(
		.DEPTH(DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.value_in  (value_in),
		.strobe    (strobe),
		.value_out (value_out),
		.status    (status),
		.last      (last)
	);

	// The checker sits beside the block and sees exactly the same pins.
	bounded_deque_engine_checker #(
		.DEPTH(DEPTH)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.value_in      (value_in),
		.strobe        (strobe),
		.value_out     (value_out),
		.status        (status),
		.last          (last),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.full_hits     (full_hits),
		.empty_hits    (empty_hits)
	);

	// Watchdog: a hung block or a lost result word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words still owed",
				cycle_count, outstanding);
			$display("Some tests failed");
			$finish;
		end
	end

	// Hands one request word to the block and returns in the time step of the
	// edge that accepts it. The sender works in bursts: when a burst runs out it
	// may drop start for a random gap before the next one begins. A request
	// that follows directly keeps start high, so start is never lowered and
	// raised within one step.
	task automatic send_request(input req_t r, input logic signed [WORD_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		start    <= 1'b1;
		req_type <= r;
		value_in <= v;
		// Busy is registered, so the value read here is the one the edge used.
		do @(posedge clk); while (busy);
		sent_by_kind[int'(r)]++;
	endtask

	// Stops sending until the checker owes nothing. The first wait lets the
	// checker account for a request taken at the current edge.
	task automatic wait_until_drained();
		start      <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Mostly full-range random words, with the extremes mixed in often.
	function automatic logic signed [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return MAX_WORD;
			1:       return MIN_WORD;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Request mix per phase. Fill pushes hard enough to reach capacity and keep
	// knocking on it; drain runs the store dry and keeps removing from empty.
	// Dumps stay rare since a full store streams out all 64 words.
	function automatic req_t pick_request(input phase_t ph);
		int roll;
		roll = $urandom_range(0, 99);
		case (ph)
			PH_FILL:
				return (roll < 48) ? REQ_APPEND : (roll < 92) ? REQ_INSERT :
					(roll < 95) ? REQ_REMOVE : REQ_DUMP;
			PH_DRAIN:
				return (roll < 5) ? REQ_APPEND : (roll < 10) ? REQ_INSERT :
					(roll < 90) ? REQ_REMOVE : REQ_DUMP;
			default:
				return (roll < 30) ? REQ_APPEND : (roll < 60) ? REQ_INSERT :
					(roll < 90) ? REQ_REMOVE : REQ_DUMP;
		endcase
	endfunction

	initial begin : stimulus
		int     random_sent;
		int     phase_len;
		phase_t ph;

		foreach (sent_by_kind[i])
			sent_by_kind[i] = 0;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		req_type <= REQ_APPEND;
		value_in <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An empty store first: remove and dump both report empty.
		send_request(REQ_REMOVE, MAX_WORD);
		send_request(REQ_DUMP, '0);
		// Extremes of the word, and an insert at slot zero that wraps the front
		// slot to the top of the ring.
		send_request(REQ_APPEND, MAX_WORD);
		send_request(REQ_INSERT, MIN_WORD);
		send_request(REQ_APPEND, '0);
		send_request(REQ_INSERT, '1);
		send_request(REQ_APPEND, 1);
		send_request(REQ_DUMP, MIN_WORD);
		send_request(REQ_REMOVE, '0);
		send_request(REQ_REMOVE, '0);
		send_request(REQ_DUMP, '0);
		send_request(REQ_INSERT, 32'sh5555_5555);
		send_request(REQ_APPEND, 32'shAAAA_AAAA);
		send_request(REQ_DUMP, '1);
		// Run the store dry, then one remove too many and a dump of nothing.
		repeat (6)
			send_request(REQ_REMOVE, pick_value());
		send_request(REQ_DUMP, '0);

		// Let everything owed arrive before the random part begins.
		wait_until_drained();

		// Random part in phases; the first fill phase is long enough to reach
		// capacity and then push against it, and the drain that follows
		// empties the store again.
		random_sent = 0;
		for (int phase_idx = 0; random_sent < RANDOM_ITEMS; phase_idx++) begin
			ph = phase_t'(phase_idx % 3);
			case (ph)
				PH_FILL:  phase_len = $urandom_range(80, 100);
				PH_DRAIN: phase_len = $urandom_range(70, 90);
				default:  phase_len = $urandom_range(30, 60);
			endcase
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				send_request(pick_request(ph), pick_value());
				random_sent++;
			end
			if ($urandom_range(0, 1) == 1)
				wait_until_drained();
		end

		// Wait for the last words, then keep watching the outputs to catch strays.
		wait_until_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d appends, %0d inserts, %0d removes and %0d dumps; %0d result words",
			sent_by_kind[int'(REQ_APPEND)], sent_by_kind[int'(REQ_INSERT)],
			sent_by_kind[int'(REQ_REMOVE)], sent_by_kind[int'(REQ_DUMP)], words_checked);
		$display("Pushes refused on a full store: %0d; requests met by an empty store: %0d",
			full_hits, empty_hits);
		if (mismatches == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
